[hdl/sts_pkg.sv]
`default_nettype none

package sts_pkg;

    // Index fields and configuration registers are ten bits wide.
    localparam int IDX_W = 10;
    // Search bounds need one bit more: the lower bound can step past the
    // highest index, and the upper bound is held as one past the last entry.
    localparam int BND_W = IDX_W + 1;

    localparam int IN_KEY_W = 32;

    // Item actions.
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_FIRST = 1'b0;
    localparam logic CFG_LAST  = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [BND_W-1:0] bnd_t;

    // Read request from the search sequencer to the key memory.
    typedef struct packed {
        logic en;
        idx_t idx;
    } rd_req_t;

endpackage

`default_nettype wire

[hdl/sts_key_mem.sv]
`default_nettype none

module sts_key_mem #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 10
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds while no read is issued, so a stalled comparison
    // keeps seeing the same entry.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/sts_search.sv]
`default_nettype none

module sts_search #(
    parameter int KEY_WIDTH = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire sts_pkg::idx_t        first_idx,
    input  wire sts_pkg::idx_t        last_idx,
    input  wire logic [KEY_WIDTH-1:0] key,
    input  wire logic [KEY_WIDTH-1:0] rd_data,
    output sts_pkg::rd_req_t          rd_req,
    output logic                      idle,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_found,
    output sts_pkg::idx_t             m_match_index
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    logic [1:0]           state_reg, state_next;
    sts_pkg::bnd_t        lo_reg, lo_next;
    sts_pkg::bnd_t        hi1_reg, hi1_next;
    sts_pkg::idx_t        mid_reg, mid_next;
    logic [KEY_WIDTH-1:0] target_reg, target_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 found_reg, found_next;
    sts_pkg::idx_t        index_reg, index_next;

    sts_pkg::bnd_t        lo0, hi1_0;
    logic [sts_pkg::BND_W:0] sum0, sum_l, sum_g;
    logic                 empty0;
    logic                 hit, go_left, ne_l, ne_g, done, out_free, load;
    sts_pkg::idx_t        mid_l, mid_g;

    // Initial window; the upper bound is kept exclusive.
    assign lo0    = {1'b0, first_idx};
    assign hi1_0  = {1'b0, last_idx} + sts_pkg::BND_W'(1);
    assign empty0 = (lo0 >= hi1_0);
    assign sum0   = {2'b00, first_idx} + {2'b00, last_idx};

    // Both candidate next probes are formed alongside the compare.
    assign hit     = (rd_data == target_reg);
    assign go_left = ($signed(target_reg) < $signed(rd_data));
    assign ne_l    = (lo_reg < {1'b0, mid_reg});
    assign ne_g    = (({1'b0, mid_reg} + sts_pkg::BND_W'(1)) < hi1_reg);
    assign sum_l   = {1'b0, lo_reg} + {2'b00, mid_reg} - (sts_pkg::BND_W + 1)'(1);
    assign sum_g   = {2'b00, mid_reg} + {1'b0, hi1_reg};
    assign mid_l   = sum_l[sts_pkg::IDX_W:1];
    assign mid_g   = sum_g[sts_pkg::IDX_W:1];
    assign done    = hit || (go_left ? !ne_l : !ne_g);

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi1_next     = hi1_reg;
        mid_next     = mid_reg;
        target_next  = target_reg;
        found_next   = found_reg;
        index_next   = index_reg;
        load         = 1'b0;
        rd_req.en    = 1'b0;
        rd_req.idx   = mid_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    lo_next     = lo0;
                    hi1_next    = hi1_0;
                    mid_next    = sum0[sts_pkg::IDX_W:1];
                    target_next = key;
                    if (empty0) begin
                        state_next = ST_EMPTY;
                    end else begin
                        rd_req.en  = 1'b1;
                        rd_req.idx = sum0[sts_pkg::IDX_W:1];
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                if (done) begin
                    // Hold the comparison until the result register frees up.
                    if (out_free) begin
                        load       = 1'b1;
                        found_next = hit;
                        index_next = hit ? mid_reg : '0;
                        state_next = ST_IDLE;
                    end
                end else if (go_left) begin
                    hi1_next   = {1'b0, mid_reg};
                    mid_next   = mid_l;
                    rd_req.en  = 1'b1;
                    rd_req.idx = mid_l;
                end else begin
                    lo_next    = {1'b0, mid_reg} + sts_pkg::BND_W'(1);
                    mid_next   = mid_g;
                    rd_req.en  = 1'b1;
                    rd_req.idx = mid_g;
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    load       = 1'b1;
                    found_next = 1'b0;
                    index_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi1_reg    <= hi1_next;
        mid_reg    <= mid_next;
        target_reg <= target_next;
        found_reg  <= found_next;
        index_reg  <= index_next;
    end

    assign idle          = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_found       = found_reg;
    assign m_match_index = index_reg;

endmodule

`default_nettype wire

[hdl/sorted_table_binary_search.sv]
// Sorted-table binary search.
// The input channel (s_valid/s_ready) carries items of two kinds. A write item
// (s_action = 0) stores s_key at table entry s_slot and gives no result;
// slots beyond the table are dropped. A search item (s_action = 1) looks for
// s_key between the window registers first_index and last_index, which the
// user must set via cfg_we/cfg_index/cfg_wdata only while the block is idle;
// the block does not enforce this. The window must already hold keys sorted
// in ascending signed order, and every entry in it must have been written.
// A search probes the floor midpoint of the current bounds once a cycle,
// one read of the key memory per probe, so a window of n entries takes at
// most floor(log2(n)) + 1 probes: eleven for the full table. The result
// (m_found, m_match_index) is registered once the last probe is compared;
// an empty window answers without a probe. One search is in flight at a
// time: the block takes no new item until the current search has ended.
// A result waiting in the output register does not block the next item;
// only a finished search whose result cannot yet be loaded holds the block.
// Reset (aresetn low, synchronous) clears the window registers and the
// handshake state; the key table keeps no reset value.
`default_nettype none

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [sts_pkg::IDX_W-1:0]     cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_action,
    input  wire logic [sts_pkg::IDX_W-1:0]     s_slot,
    input  wire logic signed [sts_pkg::IN_KEY_W-1:0] s_key,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_found,
    output logic [sts_pkg::IDX_W-1:0]          m_match_index
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [31:0] DEPTH_W  = 32'(TABLE_DEPTH);
    localparam logic [31:0] LAST_MAX = 32'(TABLE_DEPTH - 1);

    sts_pkg::idx_t        first_index_reg, first_index_next;
    sts_pkg::idx_t        last_index_reg, last_index_next;
    sts_pkg::idx_t        last_clamped;
    logic [63:0]          key_ext;
    logic [KEY_WIDTH-1:0] key_fit;
    logic [KEY_WIDTH-1:0] rd_data;
    sts_pkg::rd_req_t     rd_req;
    logic                 idle;
    logic                 accept;
    logic                 start;
    logic                 wr_en;

    always_comb begin
        first_index_next = first_index_reg;
        last_index_next  = last_index_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                sts_pkg::CFG_FIRST: first_index_next = cfg_wdata;
                sts_pkg::CFG_LAST:  last_index_next  = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_index_reg <= '0;
            last_index_reg  <= '0;
        end else begin
            first_index_reg <= first_index_next;
            last_index_reg  <= last_index_next;
        end
    end

    // The window never reaches past the end of the table.
    assign last_clamped = ({22'd0, last_index_reg} > LAST_MAX) ?
                          sts_pkg::IDX_W'(LAST_MAX) : last_index_reg;

    // The key is sign-extended, then taken at the table's key width.
    assign key_ext = {{(64 - sts_pkg::IN_KEY_W){s_key[sts_pkg::IN_KEY_W-1]}}, s_key};
    assign key_fit = key_ext[KEY_WIDTH-1:0];

    assign s_ready = idle;
    assign accept  = s_valid && s_ready;
    assign start   = accept && (s_action == sts_pkg::ACT_SEARCH);
    // Writes are taken only between searches, so no read can overlap a write
    // to the same entry and the memory needs no forwarding.
    assign wr_en   = accept && (s_action == sts_pkg::ACT_WRITE)
                     && ({22'd0, s_slot} < DEPTH_W);

    sts_key_mem #(
        .DEPTH  (TABLE_DEPTH),
        .WIDTH  (KEY_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_key_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(s_slot)),
        .wr_data (key_fit),
        .rd_en   (rd_req.en),
        .rd_addr (ADDR_W'(rd_req.idx)),
        .rd_data (rd_data)
    );

    sts_search #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_search (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (start),
        .first_idx     (first_index_reg),
        .last_idx      (last_clamped),
        .key           (key_fit),
        .rd_data       (rd_data),
        .rd_req        (rd_req),
        .idle          (idle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_match_index (m_match_index)
    );

    // A miss always reports index zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_match_index == '0))
        else $error("miss reported with a non-zero index");

    // A write item never produces a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_action == sts_pkg::ACT_WRITE)) |=> !$rose(m_valid))
        else $error("result appeared after a write item");

    // Table writes and probe reads never share a cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !rd_req.en)
        else $error("table write collided with a probe read");

    // Probe reads other than a search's first are issued only mid-search, never while idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_req.en && !start |-> !idle)
        else $error("probe read issued outside a search");

endmodule

`default_nettype wire
